### rtl/bls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;

  localparam int GRID_W    = 8;
  localparam int COLOUR_W  = 32;
  localparam int ORIGIN_W  = 13;
  localparam int GAP_W     = 7;
  localparam int COORD_W   = 16;
  localparam int SPAN_W    = 15;
  localparam int ERR_W     = 17;
  localparam int INDEX_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 56;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAP_W-1:0] GAP_MAX = 7'd64;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_GRID_GAP = 2'd2
  } cfg_idx_e;

  // Decoded command as it sits in the queue between front and back.
  typedef struct packed {
    cmd_e                       cmd;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic signed [COORD_W-1:0]  x2;
    logic signed [COORD_W-1:0]  y2;
    logic [COLOUR_W-1:0]        colour;
  } cmd_entry_t;

  // Queue read side toward the back end.
  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } queue_rd_t;

endpackage

### rtl/bls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_front
// Input side: config registers, grid-to-screen mapping, queue push.
// ----------------------------------------------------------------------------
module bls_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bls_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bls_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output bls_pkg::cmd_entry_t               push_entry_o
);

  logic signed [bls_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;
  logic [bls_pkg::GAP_W-1:0]           gap_q, gap_wr;

  // screen = origin + grid * gap; fits 16 signed bits with gap <= 64
  function automatic logic signed [bls_pkg::COORD_W-1:0] map_coord(
    input logic signed [bls_pkg::ORIGIN_W-1:0] origin,
    input logic [bls_pkg::GRID_W-1:0]          grid,
    input logic [bls_pkg::GAP_W-1:0]           gap
  );
    logic [bls_pkg::GRID_W+bls_pkg::GAP_W-1:0] prod;
    prod = {{bls_pkg::GAP_W{1'b0}}, grid} * {{bls_pkg::GRID_W{1'b0}}, gap};
    return bls_pkg::COORD_W'(origin) + $signed({1'b0, prod});
  endfunction

  assign gap_wr = (cfg_data_i[bls_pkg::GAP_W-1:0] > bls_pkg::GAP_MAX) ?
                  bls_pkg::GAP_MAX : cfg_data_i[bls_pkg::GAP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      gap_q      <= bls_pkg::GAP_W'(1);
    end else if (cfg_we_i) begin
      case (bls_pkg::cfg_idx_e'(cfg_idx_i))
        bls_pkg::CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data_i);
        bls_pkg::CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data_i);
        bls_pkg::CFG_GRID_GAP: gap_q      <= gap_wr;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    push_entry_o.cmd    = bls_pkg::cmd_e'(s_axis_tuser);
    push_entry_o.x1     = map_coord(origin_x_q, s_axis_tdata[7:0],   gap_q);
    push_entry_o.y1     = map_coord(origin_y_q, s_axis_tdata[15:8],  gap_q);
    push_entry_o.x2     = map_coord(origin_x_q, s_axis_tdata[23:16], gap_q);
    push_entry_o.y2     = map_coord(origin_y_q, s_axis_tdata[31:24], gap_q);
    push_entry_o.colour = s_axis_tdata[63:32];
  end

endmodule

### rtl/bls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module bls_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bls_pkg::cmd_entry_t  push_entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output bls_pkg::queue_rd_t   rd_o
);

  localparam int PTR_W = $clog2(bls_pkg::QUEUE_DEPTH);

  bls_pkg::cmd_entry_t mem_q [bls_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]      count_q, count_d;
  logic                do_pop;

  assign full_o   = (count_q == (PTR_W+1)'(bls_pkg::QUEUE_DEPTH));
  assign do_pop   = pop_i && (count_q != '0);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(bls_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(bls_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### rtl/bls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_back
// Line state, Bresenham stepping, pixel index stage and output register.
// ----------------------------------------------------------------------------
module bls_back #(
  parameter int SCREEN_WIDTH  = bls_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bls_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bls_pkg::queue_rd_t             rd_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bls_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int IDX_W = 32;
  localparam logic signed [IDX_W-1:0] WIDTH_S   = IDX_W'(SCREEN_WIDTH);
  localparam logic signed [IDX_W-1:0] FRAME_PIX = IDX_W'(SCREEN_WIDTH * SCREEN_HEIGHT);

  localparam int CW = bls_pkg::COORD_W;
  localparam int SW = bls_pkg::SPAN_W;
  localparam int EW = bls_pkg::ERR_W;

  // line state
  logic signed [CW-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic signed [CW-1:0] cur_x_d, cur_y_d, tgt_x_d, tgt_y_d;
  logic [SW-1:0]        span_x_q, span_y_q, span_x_d, span_y_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 xdn_q, ydn_q, xdn_d, ydn_d;
  logic [bls_pkg::COLOUR_W-1:0] colour_q, colour_d;
  logic                 drawing_q, drawing_d;

  // pixel stage
  logic                 p1_valid_q;
  logic signed [CW-1:0] p1_x_q, p1_y_q;
  logic                 p1_last_q;
  logic [bls_pkg::COLOUR_W-1:0] p1_colour_q;

  // output register
  logic                 out_valid_q;
  logic [bls_pkg::INDEX_W-1:0]  out_index_q;
  logic [bls_pkg::COLOUR_W-1:0] out_colour_q;
  logic                 out_inframe_q, out_last_q;

  logic out_load, p1_free, is_start, emit, at_end;
  logic signed [CW-1:0]   dx, dy;
  logic signed [EW:0]     e2, sum;
  logic signed [EW+1:0]   neg_sy;
  logic                   step_x, step_y;
  logic signed [IDX_W-1:0] idx;
  logic                   idx_ok;

  assign out_load = !out_valid_q || m_axis_tready;
  assign p1_free  = !p1_valid_q || out_load;
  assign is_start = (rd_i.entry.cmd == bls_pkg::CMD_START);
  assign emit     = rd_i.valid && !is_start && drawing_q && p1_free;
  assign pop_o    = rd_i.valid && (is_start || !drawing_q || p1_free);
  assign at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  // error step
  assign e2     = {err_q, 1'b0};
  assign neg_sy = -$signed({4'b0000, span_y_q});
  assign step_x = (EW+2)'(e2) > neg_sy;
  assign step_y = e2 <= $signed({3'b000, span_x_q});
  assign sum    = (EW+1)'(err_q) - (step_x ? $signed({3'b000, span_y_q}) : (EW+1)'(0))
                                 + (step_y ? $signed({3'b000, span_x_q}) : (EW+1)'(0));

  // start setup
  assign dx = rd_i.entry.x2 - rd_i.entry.x1;
  assign dy = rd_i.entry.y2 - rd_i.entry.y1;

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    tgt_x_d   = tgt_x_q;
    tgt_y_d   = tgt_y_q;
    span_x_d  = span_x_q;
    span_y_d  = span_y_q;
    err_d     = err_q;
    xdn_d     = xdn_q;
    ydn_d     = ydn_q;
    colour_d  = colour_q;
    drawing_d = drawing_q;
    if (rd_i.valid && is_start) begin
      span_x_d  = dx[CW-1] ? SW'(-dx) : SW'(dx);
      span_y_d  = dy[CW-1] ? SW'(-dy) : SW'(dy);
      err_d     = EW'($signed({2'b00, span_x_d})) - EW'($signed({2'b00, span_y_d}));
      xdn_d     = !(rd_i.entry.x1 < rd_i.entry.x2);
      ydn_d     = !(rd_i.entry.y1 < rd_i.entry.y2);
      cur_x_d   = rd_i.entry.x1;
      cur_y_d   = rd_i.entry.y1;
      tgt_x_d   = rd_i.entry.x2;
      tgt_y_d   = rd_i.entry.y2;
      colour_d  = rd_i.entry.colour;
      drawing_d = 1'b1;
    end else if (emit) begin
      if (at_end) begin
        drawing_d = 1'b0;
      end else begin
        err_d = EW'(sum);
        if (step_x) cur_x_d = xdn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        if (step_y) cur_y_d = ydn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      span_x_q  <= '0;
      span_y_q  <= '0;
      err_q     <= '0;
      xdn_q     <= 1'b0;
      ydn_q     <= 1'b0;
      colour_q  <= '0;
      drawing_q <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      tgt_x_q   <= tgt_x_d;
      tgt_y_q   <= tgt_y_d;
      span_x_q  <= span_x_d;
      span_y_q  <= span_y_d;
      err_q     <= err_d;
      xdn_q     <= xdn_d;
      ydn_q     <= ydn_d;
      colour_q  <= colour_d;
      drawing_q <= drawing_d;
    end
  end

  // pixel stage: captures the position before it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (p1_free) begin
      p1_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      p1_x_q      <= cur_x_q;
      p1_y_q      <= cur_y_q;
      p1_last_q   <= at_end;
      p1_colour_q <= colour_q;
    end
  end

  // linear index and frame check
  assign idx    = IDX_W'(p1_x_q) + IDX_W'(p1_y_q) * WIDTH_S;
  assign idx_ok = !idx[IDX_W-1] && (idx < FRAME_PIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && p1_valid_q) begin
      out_index_q   <= idx_ok ? idx[bls_pkg::INDEX_W-1:0] : '0;
      out_colour_q  <= p1_colour_q;
      out_inframe_q <= idx_ok;
      out_last_q    <= p1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bls_pkg::M_TDATA_W - bls_pkg::INDEX_W - bls_pkg::COLOUR_W){1'b0}},
                          out_colour_q, out_index_q};
  assign m_axis_tuser  = out_inframe_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/bresenham_line_pixel_stepper_top.sv
`timescale 1ns / 1ps
// A step transfer is written into the queue, then passes the pixel stage and the output register to m_axis.
// Throughput: one item per cycle, starts and steps alike, while the pixel side is not stalled;
//   set by the error-term update in the back end.
// Reset (rst_ni, async, active low) empties the queue and pipeline, leaves the
//   stepper idle, origins at 0 and grid gap at 1.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_stepper_top
// Line rasterizer: grid endpoints in, one framebuffer pixel per step out.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_stepper_top #(
  parameter int SCREEN_WIDTH  = bls_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bls_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] start_grid_x, [15:8] start_grid_y, [23:16] end_grid_x,
  // [31:24] end_grid_y, [63:32] line_colour
  input  logic [bls_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] command: 0 start line, 1 step
  input  logic                              s_axis_tuser,
  // Pixel stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] pixel_index, [51:20] pixel_colour, [55:52] zero
  output logic [bls_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] in_frame (write enable)
  output logic                              m_axis_tuser,
  // last_pixel
  output logic                              m_axis_tlast,
  // Config writes: 0 origin_x, 1 origin_y, 2 grid_gap
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bls_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Front maps endpoints to screen space as each transfer arrives and pushes a
  // decoded command; the queue lets input keep flowing while the pixel side
  // is stalled, and lets the back end run while input is idle.
  logic                 q_full, push, pop;
  bls_pkg::cmd_entry_t  push_entry;
  bls_pkg::queue_rd_t   q_rd;

  bls_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  bls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .rd_o         (q_rd)
  );

  // Back end: a start sets up spans/error/directions; a step while drawing
  // emits the current position, then advances. Steps while idle are dropped.
  // The index multiply sits in its own stage ahead of the
  // output register.
  bls_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_i          (q_rd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/bls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks on the line pixel stepper.
// ----------------------------------------------------------------------------
module bls_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bls_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // pixel held until taken
  a_m_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("pixel dropped while stalled");

  a_m_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("pixel changed while stalled");

  // off-frame pixels carry a zero index
  a_off_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[bls_pkg::INDEX_W-1:0] == '0)
    else $error("off-frame pixel with nonzero index");

  // queue comes out of reset empty
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not ready after reset");

endmodule

bind bresenham_line_pixel_stepper_top bls_checker u_bls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### verif/bresenham_line_pixel_stepper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_stepper_top_tb
// Self-checking bench for the line stepper. A scripted table covers the
// reset setting, single-pixel lines, the grid corners and all four step
// directions. Random line sequences then run under several origin and gap
// settings, with random gaps and stalls on both streams. Every pixel transfer
// is checked against the scripted pixel or an in-bench model of the stepper.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_stepper_top_tb;

  localparam int SCREEN_W = bls_pkg::SCREEN_WIDTH_DEF;
  localparam int SCREEN_H = bls_pkg::SCREEN_HEIGHT_DEF;

  localparam logic [bls_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;  // no register behind it

  localparam int HOLD_CYCLES    = 300;   // one long sink hold-off
  localparam int DRAIN_CYCLES   = 8;     // pixel stage and output register plus a 2-deep queue
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS    = 50;

  // One input item as the stream carries it.
  typedef struct packed {
    bls_pkg::cmd_e cmd;
    logic [7:0]    sx;
    logic [7:0]    sy;
    logic [7:0]    ex;
    logic [7:0]    ey;
    logic [31:0]   colour;
  } line_cmd_t;

  // One pixel as the stream carries it.
  typedef struct packed {
    logic [19:0] pix_index;
    logic [31:0] colour;
    logic        in_frame;
    logic        last;
  } pixel_t;

  // Scripted stimulus; typed=1 means px / has_px hold the expected outcome.
  typedef struct packed {
    line_cmd_t item;
    bit        typed;
    bit        has_px;
    pixel_t    px;
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [bls_pkg::S_TDATA_W-1:0]   s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [bls_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we_i;
  logic [bls_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [bls_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  // Model copy of the registers and the stepper state.
  int          org_x = 0;
  int          org_y = 0;
  int          gap   = 1;
  int          cur_x = 0;
  int          cur_y = 0;
  int          tgt_x = 0;
  int          tgt_y = 0;
  int          span_x = 0;
  int          span_y = 0;
  int          err_term = 0;
  bit          x_down = 1'b0;
  bit          y_down = 1'b0;
  bit          drawing = 1'b0;
  logic [31:0] colour_q = '0;

  pixel_t      pending_pixels[$];
  dir_row_t    directed_rows[$];

  int          err_cnt = 0;
  int          pixels_checked = 0;
  int          lines_started = 0;
  int          settings_cnt = 1;
  int          stall_cnt = 0;
  bit          hold_armed = 1'b0;
  bit          hold_active = 1'b0;
  bit          hold_done = 1'b0;

  bresenham_line_pixel_stepper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void apply_cfg(logic [bls_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bls_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bls_pkg::CFG_ORIGIN_X: org_x = int'($signed(data));
      bls_pkg::CFG_ORIGIN_Y: org_y = int'($signed(data));
      bls_pkg::CFG_GRID_GAP: gap = (data[6:0] > bls_pkg::GAP_MAX) ? int'(bls_pkg::GAP_MAX)
                                                                 : int'(data[6:0]);
      default: ;  // unmapped index: no effect
    endcase
  endfunction

  // Line stepper model: a start sets up the line, a step emits the current
  // pixel and then moves one Bresenham step toward the end point.
  function automatic void plot_step(input line_cmd_t it, output bit emits, output pixel_t px);
    int     x1, y1, x2, y2, e2;
    longint lin;
    emits = 1'b0;
    px = '0;
    if (it.cmd == bls_pkg::CMD_START) begin
      x1 = org_x + int'(it.sx) * gap;
      y1 = org_y + int'(it.sy) * gap;
      x2 = org_x + int'(it.ex) * gap;
      y2 = org_y + int'(it.ey) * gap;
      span_x = (x2 > x1) ? x2 - x1 : x1 - x2;
      span_y = (y2 > y1) ? y2 - y1 : y1 - y2;
      err_term = span_x - span_y;
      x_down = !(x1 < x2);
      y_down = !(y1 < y2);
      cur_x = x1;
      cur_y = y1;
      tgt_x = x2;
      tgt_y = y2;
      colour_q = it.colour;
      drawing = 1'b1;  // a start while drawing simply replaces the line
    end else if (drawing) begin
      emits = 1'b1;
      lin = longint'(cur_x) + longint'(cur_y) * SCREEN_W;
      // frame test is on the linear index only; off-frame pixels report index 0
      px.in_frame = (lin >= 0) && (lin < longint'(SCREEN_W) * SCREEN_H);
      px.pix_index = px.in_frame ? lin[19:0] : '0;
      px.colour = colour_q;
      px.last = (cur_x == tgt_x) && (cur_y == tgt_y);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        e2 = err_term * 2;
        if (e2 > -span_y) begin
          err_term -= span_y;
          cur_x += x_down ? -1 : 1;
        end
        if (e2 <= span_x) begin
          err_term += span_x;
          cur_y += y_down ? -1 : 1;
        end
      end
    end
  endfunction

  function automatic void add_row(bls_pkg::cmd_e cmd, logic [7:0] sx, logic [7:0] sy,
                                  logic [7:0] ex, logic [7:0] ey, logic [31:0] colour,
                                  bit typed, bit has_px, logic [19:0] pix_index,
                                  logic in_frame, logic last);
    dir_row_t r;
    r.item = '{cmd, sx, sy, ex, ey, colour};
    r.typed = typed;
    r.has_px = has_px;
    r.px = '{pix_index, colour, in_frame, last};
    directed_rows.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Offer one item, wait for its transfer, then run the model on it.
  task automatic send_item(input line_cmd_t it, input bit no_gap, output bit emits,
                           output pixel_t px);
    int gap_len;
    gap_len = no_gap ? 0 : idle_len();
    if (gap_len > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {it.colour, it.ey, it.ex, it.sy, it.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    plot_step(it, emits, px);
    if (it.cmd == bls_pkg::CMD_START) lines_started++;
  endtask

  task automatic send_and_predict(input line_cmd_t it, input bit no_gap, inout int counted);
    bit     emits;
    pixel_t px;
    send_item(it, no_gap, emits, px);
    if (emits) pending_pixels.push_back(px);
    if (emits || it.cmd == bls_pkg::CMD_START) counted++;  // idle steps do not count
  endtask

  // Wait until every expected pixel is out, plus the pipe depth for any
  // trailing items that produce nothing.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [bls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bls_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_cfg(idx, data);
  endtask

  task automatic load_settings(input logic [bls_pkg::CFG_DATA_W-1:0] ox,
                               input logic [bls_pkg::CFG_DATA_W-1:0] oy,
                               input logic [bls_pkg::CFG_DATA_W-1:0] gap_data);
    cfg_write(bls_pkg::CFG_ORIGIN_X, ox);
    cfg_write(bls_pkg::CFG_ORIGIN_Y, oy);
    cfg_write(bls_pkg::CFG_GRID_GAP, gap_data);
    cfg_write(CFG_UNMAPPED, bls_pkg::CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  // Mostly well-formed lines (start then exactly its pixel count of steps),
  // plus abandoned lines, surplus idle steps and raw noise items.
  task automatic random_phase(input int budget);
    int        counted, kind, maxd, steps, npix, bx, by, v, dx, dy;
    bit        burst;
    line_cmd_t it;
    counted = 0;
    while (counted < budget) begin
      kind  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 4) == 0);
      it.cmd = bls_pkg::CMD_START;
      it.colour = $urandom();
      if (kind >= 95) begin
        it.cmd = bls_pkg::cmd_e'($urandom_range(0, 1));
        {it.ey, it.ex, it.sy, it.sx} = $urandom();
        send_and_predict(it, burst, counted);
        continue;
      end
      if (gap == 1 && kind >= 90) begin
        {it.ey, it.ex, it.sy, it.sx} = $urandom();  // full-range line
      end else begin
        // short lines: major axis up to 24 screen pixels, or one grid step when gap > 24
        maxd = (gap == 0) ? 255 : ((24 / gap) > 0 ? 24 / gap : 1);
        bx = $urandom_range(0, 255);
        by = $urandom_range(0, 255);
        it.sx = bx[7:0];
        it.sy = by[7:0];
        v = bx + $urandom_range(0, 2 * maxd) - maxd;
        it.ex = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        v = by + $urandom_range(0, 2 * maxd) - maxd;
        it.ey = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
      dx = int'(it.ex) - int'(it.sx);
      dy = int'(it.ey) - int'(it.sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      npix = ((dx > dy) ? dx : dy) * gap + 1;
      if (kind < 70) steps = npix;
      else if (kind < 82) steps = $urandom_range(0, npix - 1);  // abandoned by next start
      else steps = npix + $urandom_range(1, 3);                 // steps while idle
      send_and_predict(it, burst, counted);
      repeat (steps) begin
        it.cmd = bls_pkg::CMD_STEP;
        {it.ey, it.ex, it.sy, it.sx} = $urandom();  // payload of a step is ignored
        it.colour = $urandom();
        send_and_predict(it, burst, counted);
      end
    end
  endtask

  // Result sink: random ready pattern, plus one long hold-off once armed.
  initial begin : pixel_sink
    int run_len;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    forever begin
      if (hold_armed && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= 1'b1;
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      run_len = idle_len();
      if (run_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (run_len) @(posedge clk_i);
      end
    end
  end

  // Compare each pixel transfer with the oldest expected pixel.
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with no pixel expected: tdata=%h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_index", 32'(want.pix_index), 32'(m_axis_tdata[19:0]));
        check_field("pixel_colour", want.colour, m_axis_tdata[51:20]);
        check_field("tdata_pad", '0, 32'(m_axis_tdata[55:52]));
        check_field("in_frame", 32'(want.in_frame), 32'(m_axis_tuser));
        check_field("last_pixel", 32'(want.last), 32'(m_axis_tlast));
        pixels_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither stream moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d pixels outstanding",
               stall_cnt, pending_pixels.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    bit     emits;
    pixel_t px;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bls_pkg::CMD_START;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bls_pkg::CFG_ORIGIN_X;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Scripted part at the reset setting: origin 0, gap 1.
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 1, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 1, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 1, 1, 20'd0, 1, 1);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 1, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_START, 8'd255, 8'd255, 8'd255, 8'd255, 32'h0, 1, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 1, 1, 20'd261375, 1, 1);
    add_row(bls_pkg::CMD_START, 8'd0, 8'd0, 8'd255, 8'd0, 32'hA5A5_A5A5, 1, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'hA5A5_A5A5, 1, 1, 20'd0, 1, 0);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'hA5A5_A5A5, 1, 1, 20'd1, 1, 0);
    // start while drawing: x decreasing, y increasing
    add_row(bls_pkg::CMD_START, 8'd6, 8'd2, 8'd1, 8'd4, 32'h0F0F_0F0F, 0, 0, 20'd0, 0, 0);
    repeat (6) add_row(bls_pkg::CMD_STEP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0, 0, 0, 20'd0, 0, 0);
    // x increasing, y decreasing, steep
    add_row(bls_pkg::CMD_START, 8'd2, 8'd6, 8'd4, 8'd1, 32'hF0F0_F0F0, 0, 0, 20'd0, 0, 0);
    repeat (6) add_row(bls_pkg::CMD_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 0, 0, 20'd0, 0, 0);
    add_row(bls_pkg::CMD_STEP,  8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 0, 0, 20'd0, 0, 0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, 1'b0, emits, px);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_px) pending_pixels.push_back(directed_rows[i].px);
      end else if (emits) begin
        pending_pixels.push_back(px);
      end
    end
    settle();

    // Most negative origin, gap field 64 with junk in the upper data bits.
    // The sink's long hold-off starts before this phase sends, so the queue
    // fills and the input stalls while items are still offered.
    load_settings(13'h1000, 13'h1000, 13'h1F40);
    hold_armed = 1'b1;
    wait (hold_active);
    random_phase(PHASE_ITEMS);
    settle();

    // Most positive origin, gap written as 127 which saturates to 64.
    load_settings(13'h0FFF, 13'h0FFF, 13'h007F);
    random_phase(PHASE_ITEMS);
    settle();

    // Gap of zero: every line collapses to one pixel at the origin.
    load_settings(13'h1FFF, 13'd100, 13'h0000);
    random_phase(PHASE_ITEMS);
    settle();

    repeat (3) begin
      load_settings(bls_pkg::CFG_DATA_W'($urandom()),
                    bls_pkg::CFG_DATA_W'($urandom_range(0, 600)),
                    {6'($urandom()), 7'($urandom_range(1, 8))});
      random_phase(PHASE_ITEMS);
      settle();
    end

    // Back to origin 0, gap 1, where full-range lines appear.
    load_settings(13'd0, 13'd0, 13'd1);
    random_phase(PHASE_ITEMS);
    settle();

    $display("Run covered %0d lines under %0d register settings; %0d pixels checked, %0d errors",
             lines_started, settings_cnt, pixels_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/bls_pkg.sv
rtl/bls_front.sv
rtl/bls_queue.sv
rtl/bls_back.sv
rtl/bresenham_line_pixel_stepper_top.sv
rtl/bls_checker.sv
verif/bresenham_line_pixel_stepper_top_tb.sv
